// ===== src/sbus_frame_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// SBUS frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define SBUS_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication
`define SBUS_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define SBUS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/sbus_rx_pkg.sv =====
// ---------------------------------------------------------------------------
// SBUS receiver package
// Frame constants, event and status codes, transaction types and helpers.
// ---------------------------------------------------------------------------
package sbus_rx_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int POS_W       = 5;
  localparam int CNT_W       = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;   // 8-bit counter ceiling
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(FRAME_BYTES);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_START_VALUE = 1'b0,
    REG_END_VALUE   = 1'b1
  } sbus_reg_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_LINE_ERR = 2'd1,
    KIND_IDLE_GAP = 2'd2
  } sbus_kind_t;

  typedef enum logic [2:0] {
    STATUS_MID_BYTE   = 3'd0,
    STATUS_START_OK   = 3'd1,
    STATUS_START_REJ  = 3'd2,
    STATUS_FRAME_OK   = 3'd3,
    STATUS_FRAME_DROP = 3'd4,
    STATUS_ERR_RESET  = 3'd5,
    STATUS_GAP_NOTED  = 3'd6
  } sbus_status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       parity_error;
    logic       framing_error;
    logic       noise_error;
    logic       overrun_error;
  } sbus_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [POS_W-1:0] byte_position;
    logic             byte_stored;
    logic             frame_ready;
    logic [2:0]       status;
    logic [CNT_W-1:0] parity_count;
    logic [CNT_W-1:0] framing_count;
    logic [CNT_W-1:0] noise_count;
    logic [CNT_W-1:0] overrun_count;
  } sbus_result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] count);
    return (count == COUNT_MAX) ? count : count + CNT_W'(1);
  endfunction

endpackage

// ===== src/sbus_rx_core.sv =====
// ---------------------------------------------------------------------------
// SBUS receiver core
// Byte position and gap tracking, frame checks and saturating error counters.
// ---------------------------------------------------------------------------
`include "sbus_frame_receiver_defines.svh"

module sbus_rx_core
  import sbus_rx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  sbus_item_t   item,
  input  logic [7:0]   start_value,
  input  logic [7:0]   end_value,
  output sbus_result_t result
);

  logic [POS_W-1:0] position, position_next, pos_cur;
  logic             gap_seen, gap_seen_next;
  logic [CNT_W-1:0] parity_errors, parity_errors_next;
  logic [CNT_W-1:0] framing_errors, framing_errors_next;
  logic [CNT_W-1:0] noise_errors, noise_errors_next;
  logic [CNT_W-1:0] overrun_errors, overrun_errors_next;
  logic             any_error;

  always_comb begin
    pos_cur             = (position >= FRAME_LEN) ? '0 : position;
    position_next       = pos_cur;
    gap_seen_next       = gap_seen;
    parity_errors_next  = parity_errors;
    framing_errors_next = framing_errors;
    noise_errors_next   = noise_errors;
    overrun_errors_next = overrun_errors;
    any_error           = item.parity_error | item.framing_error |
                          item.noise_error | item.overrun_error;
    result              = '0;
    result.status       = STATUS_MID_BYTE;

    unique case (item.kind)
      KIND_BYTE: begin
        result.out_byte      = item.rx_byte;
        result.byte_position = pos_cur;
        result.byte_stored   = 1'b1;
        priority if (pos_cur == '0) begin
          gap_seen_next = 1'b0;
          if (item.rx_byte == start_value && gap_seen) begin
            position_next = POS_W'(1);
            result.status = STATUS_START_OK;
          end else begin
            position_next = '0;
            result.status = STATUS_START_REJ;
          end
        end else if (pos_cur == LAST_POS) begin
          position_next = '0;
          gap_seen_next = 1'b0;
          if (item.rx_byte == end_value && !gap_seen) begin
            result.frame_ready = 1'b1;
            result.status      = STATUS_FRAME_OK;
          end else begin
            result.status = STATUS_FRAME_DROP;
          end
        end else begin
          position_next = pos_cur + POS_W'(1);
        end
      end
      KIND_LINE_ERR: begin
        if (item.parity_error)  parity_errors_next  = sat_inc(parity_errors);
        if (item.framing_error) framing_errors_next = sat_inc(framing_errors);
        if (item.noise_error)   noise_errors_next   = sat_inc(noise_errors);
        if (item.overrun_error) overrun_errors_next = sat_inc(overrun_errors);
        if (any_error) begin
          position_next = '0;
          gap_seen_next = 1'b0;
          result.status = STATUS_ERR_RESET;
        end
      end
      KIND_IDLE_GAP: begin
        gap_seen_next = 1'b1;
        result.status = STATUS_GAP_NOTED;
      end
      default: begin
        // unused code: no state change
      end
    endcase

    result.parity_count  = parity_errors_next;
    result.framing_count = framing_errors_next;
    result.noise_count   = noise_errors_next;
    result.overrun_count = overrun_errors_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      gap_seen       <= 1'b0;
      parity_errors  <= '0;
      framing_errors <= '0;
      noise_errors   <= '0;
      overrun_errors <= '0;
    end else if (step) begin
      position       <= position_next;
      gap_seen       <= gap_seen_next;
      parity_errors  <= parity_errors_next;
      framing_errors <= framing_errors_next;
      noise_errors   <= noise_errors_next;
      overrun_errors <= overrun_errors_next;
    end
  end

  `SBUS_ASSERT_HOLDS(a_pos_in_frame, position < FRAME_LEN, "position outside frame")
  `SBUS_ASSERT_IMPLIES(a_ready_is_ok, step && result.frame_ready, result.status == STATUS_FRAME_OK, "frame_ready without frame ok status")
  `SBUS_ASSERT_NEXT(a_start_clears_gap, step && item.kind == KIND_BYTE && position == '0, !gap_seen, "gap flag survived start byte")
  `SBUS_ASSERT_NEXT(a_parity_no_drop, !rst, parity_errors >= $past(parity_errors), "parity counter went down")

endmodule

// ===== src/sbus_rx_outq.sv =====
// ---------------------------------------------------------------------------
// SBUS receiver result queue
// Two-entry result buffer: an output register plus a skid slot.
// ---------------------------------------------------------------------------
`include "sbus_frame_receiver_defines.svh"

module sbus_rx_outq
  import sbus_rx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sbus_result_t push_data,
  output logic         full,
  output logic         result_valid,
  input  logic         result_ready,
  output sbus_result_t result
);

  sbus_result_t slot0, slot1;
  logic [1:0]   count;
  logic         pop;

  assign pop          = result_valid & result_ready;
  assign full         = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload slots carry no reset
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= push_data;
        else               slot1 <= push_data;
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_data;
        end else begin
          slot0 <= slot1;
          slot1 <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

  `SBUS_ASSERT_HOLDS(a_count_bound, count <= 2'd2, "queue count out of range")
  `SBUS_ASSERT_IMPLIES(a_no_push_full, push, !full, "push into full queue")
  `SBUS_ASSERT_NEXT(a_last_pop_empties, pop && !push && count == 2'd1, !result_valid, "queue not empty after last pop")

endmodule

// ===== src/sbus_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// SBUS frame receiver
// Deframes SBUS receive events and echoes each byte with its frame position.
// Results: the core result for each accepted transaction is registered in the result queue.
// Throughput: one transaction per cycle while the result queue has a free slot;
//   the two-entry result queue lets input keep flowing while a result waits for result_ready.
// Reset: synchronous rst clears position, gap flag, error counters and queue,
//   and loads start_value 0x0F and end_value 0x00.
// ---------------------------------------------------------------------------
module sbus_frame_receiver
  import sbus_rx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // receive event transactions
  input  logic              item_valid,
  output logic              item_ready,
  input  sbus_item_t        item,
  // result transactions
  output logic              result_valid,
  input  logic              result_ready,
  output sbus_result_t      result,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic         step;
  logic         q_full;
  logic         cfg_write;
  logic [7:0]   start_value;
  logic [7:0]   end_value;
  sbus_result_t core_result;

  // --- configuration registers ---------------------------------------------
  // Always ready; the register is picked by paddr[2] (byte addresses 0 and 4).
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= 8'h0F;
      end_value   <= 8'h00;
    end else if (cfg_write) begin
      unique case (sbus_reg_t'(paddr[2]))
        REG_START_VALUE: start_value <= pwdata[7:0];
        REG_END_VALUE:   end_value   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (sbus_reg_t'(paddr[2]))
      REG_START_VALUE: prdata = APB_DW'(start_value);
      REG_END_VALUE:   prdata = APB_DW'(end_value);
    endcase
  end

  // --- receive path ----------------------------------------------------------
  // An event is taken whenever the result queue has a free slot; the core
  // works it out in the same cycle and the result lands in the queue.
  assign item_ready = ~q_full;
  assign step       = item_valid & item_ready;

  sbus_rx_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .start_value (start_value),
    .end_value   (end_value),
    .result      (core_result)
  );

  // Output register plus skid slot: decouples result_ready from item_ready.
  sbus_rx_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (step),
    .push_data    (core_result),
    .full         (q_full),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== tb/sbus_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SBUS frame receiver testbench
// Drives receive events (bytes, line errors, idle gaps) through the item
// channel while a scoreboard tracks frame position, gap flag and error
// counters. Each result transaction is checked field by field against the
// scoreboard's prediction. Start and end bytes are reprogrammed over APB
// between phases, with idle and stall patterns varied from phase to phase.
// ---------------------------------------------------------------------------
module sbus_frame_receiver_tb;
  import sbus_rx_pkg::*;

  // event code with no meaning to the block
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // -------------------------------------------------------------------------
  // Scoreboard: follows the deframer state and queues the echo expected for
  // every accepted event transaction.
  // -------------------------------------------------------------------------
  class deframe_scoreboard;
    logic [7:0]       start_byte;
    logic [7:0]       end_byte;
    logic [POS_W-1:0] pos;
    bit               gap;
    logic [CNT_W-1:0] par_cnt, frm_cnt, nse_cnt, ovr_cnt;
    sbus_result_t     expected_echoes[$];
    int unsigned      fails, echoes, frames_ok, frames_dropped, starts_ok, err_resets;

    function new();
      start_byte = 8'h0F;
      end_byte   = 8'h00;
      pos        = '0;
      gap        = 1'b0;
      par_cnt    = '0;
      frm_cnt    = '0;
      nse_cnt    = '0;
      ovr_cnt    = '0;
    endfunction

    // counters stick at their ceiling
    function logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
      return (c != '1) ? c + 1'b1 : c;
    endfunction

    function void accept_event(sbus_item_t ev);
      sbus_result_t r;
      r = '0;
      if (pos >= FRAME_LEN) pos = '0;
      case (ev.kind)
        KIND_BYTE: begin
          r.out_byte      = ev.rx_byte;
          r.byte_position = pos;
          r.byte_stored   = 1'b1;
          if (pos == '0) begin
            // first byte: needs the start value and a gap ahead of it
            if (ev.rx_byte != start_byte || !gap) begin
              r.status = STATUS_START_REJ;
            end else begin
              pos      = POS_W'(1);
              r.status = STATUS_START_OK;
              starts_ok++;
            end
            gap = 1'b0;
          end else if (pos == LAST_POS) begin
            // last byte: frame only counts if end value and no gap mid-frame
            if (ev.rx_byte == end_byte && !gap) begin
              r.frame_ready = 1'b1;
              r.status      = STATUS_FRAME_OK;
              frames_ok++;
            end else begin
              r.status = STATUS_FRAME_DROP;
              frames_dropped++;
            end
            pos = '0;
            gap = 1'b0;
          end else begin
            pos      = pos + 1'b1;
            r.status = STATUS_MID_BYTE;
          end
        end
        KIND_LINE_ERR: begin
          if (ev.parity_error)  par_cnt = count_up(par_cnt);
          if (ev.framing_error) frm_cnt = count_up(frm_cnt);
          if (ev.noise_error)   nse_cnt = count_up(nse_cnt);
          if (ev.overrun_error) ovr_cnt = count_up(ovr_cnt);
          // an error event with no flag is ignored
          if (ev.parity_error || ev.framing_error || ev.noise_error || ev.overrun_error) begin
            pos      = '0;
            gap      = 1'b0;
            r.status = STATUS_ERR_RESET;
            err_resets++;
          end
        end
        KIND_IDLE_GAP: begin
          gap      = 1'b1;
          r.status = STATUS_GAP_NOTED;
        end
        default: ;  // unused kind: no state change, status mid byte
      endcase
      r.parity_count  = par_cnt;
      r.framing_count = frm_cnt;
      r.noise_count   = nse_cnt;
      r.overrun_count = ovr_cnt;
      expected_echoes.push_back(r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fails++;
      end
    endfunction

    function void check_echo(sbus_result_t got);
      sbus_result_t want;
      if (expected_echoes.size() == 0) begin
        $error("result transaction with nothing expected: 0x%0h", got);
        fails++;
        return;
      end
      want = expected_echoes.pop_front();
      echoes++;
      check_field("out_byte",      32'(want.out_byte),      32'(got.out_byte));
      check_field("byte_position", 32'(want.byte_position), 32'(got.byte_position));
      check_field("byte_stored",   32'(want.byte_stored),   32'(got.byte_stored));
      check_field("frame_ready",   32'(want.frame_ready),   32'(got.frame_ready));
      check_field("status",        32'(want.status),        32'(got.status));
      check_field("parity_count",  32'(want.parity_count),  32'(got.parity_count));
      check_field("framing_count", 32'(want.framing_count), 32'(got.framing_count));
      check_field("noise_count",   32'(want.noise_count),   32'(got.noise_count));
      check_field("overrun_count", 32'(want.overrun_count), 32'(got.overrun_count));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT signals
  // -------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  sbus_item_t        item;
  logic              result_valid;
  logic              result_ready;
  sbus_result_t      result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  deframe_scoreboard sb = new();

  int send_idle_pct  = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;   // chance per cycle that result_ready is low
  int unsigned events_sent = 0;  // transactions that the block acts upon

  sbus_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Both channels are sampled at the same edge as the handshake, before any
  // testbench update of that edge lands. A result is registered in the queue
  // after its event is taken, so order within this block does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_echo(result);
      if (item_valid && item_ready) sb.accept_event(item);
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  function automatic sbus_item_t make_event(logic [1:0] k, logic [7:0] b, logic [3:0] f);
    sbus_item_t ev;
    ev.kind          = k;
    ev.rx_byte       = b;
    ev.parity_error  = f[3];
    ev.framing_error = f[2];
    ev.noise_error   = f[1];
    ev.overrun_error = f[0];
    return ev;
  endfunction

  // Offers one event transaction and returns at the edge that accepts it.
  // valid stays up on return so back-to-back transactions need no gap.
  task automatic send_event(input sbus_item_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= ev;
    do @(posedge clk); while (!item_ready);
    if (!(ev.kind == KIND_UNUSED ||
          (ev.kind == KIND_LINE_ERR && {ev.parity_error, ev.framing_error,
                                        ev.noise_error, ev.overrun_error} == 4'b0000)))
      events_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(make_event(KIND_BYTE, b, 4'($urandom)));
  endtask

  task automatic send_gap();
    send_event(make_event(KIND_IDLE_GAP, 8'($urandom), 4'($urandom)));
  endtask

  task automatic send_error(input logic [3:0] f);
    send_event(make_event(KIND_LINE_ERR, 8'($urandom), f));
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input sbus_reg_t idx, input logic [7:0] val);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // write lands at this edge; start the read setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(val)) begin
      $error("register %s read-back: expected 0x%0h, got 0x%0h", idx.name(), val, got);
      sb.fails++;
    end
    if (idx == REG_START_VALUE) sb.start_byte = val;
    else sb.end_byte = val;
  endtask

  // wait for every echo, then let the result queue settle;
  // the first edge lets the monitor log the last accepted transaction
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_echoes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A frame as a transmitter sends it, now and then broken: cut short, a gap
  // or line error mid-frame, a stray ignored event, or wrong start/end bytes.
  task automatic send_frame();
    int cut, gap_at, err_at, odd_at;
    logic [7:0] b;
    cut    = ($urandom_range(0, 99) < 6)  ? $urandom_range(2, FRAME_BYTES - 2) : FRAME_BYTES;
    gap_at = ($urandom_range(0, 99) < 10) ? $urandom_range(1, FRAME_BYTES - 1) : -1;
    err_at = ($urandom_range(0, 99) < 6)  ? $urandom_range(1, FRAME_BYTES - 1) : -1;
    odd_at = ($urandom_range(0, 99) < 5)  ? $urandom_range(1, FRAME_BYTES - 1) : -1;
    repeat ($urandom_range(1, 2)) send_gap();
    for (int i = 0; i < cut; i++) begin
      if (i == gap_at) send_gap();
      if (i == err_at) send_error(4'($urandom_range(1, 15)));
      if (i == odd_at) begin
        if ($urandom_range(0, 1)) send_event(make_event(KIND_UNUSED, 8'($urandom),
                                                        4'($urandom)));
        else send_error(4'b0000);
      end
      if (i == 0)
        b = ($urandom_range(0, 99) < 90) ? sb.start_byte : 8'($urandom);
      else if (i == FRAME_BYTES - 1)
        b = ($urandom_range(0, 99) < 80) ? sb.end_byte : 8'($urandom);
      else
        b = 8'($urandom);
      send_byte(b);
    end
  endtask

  // Mix of frames, error bursts and loose single events
  task automatic run_random(input int unsigned n);
    int unsigned target;
    int pick;
    target = events_sent + n;
    while (events_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 12)) send_error(4'($urandom));
      end else begin
        send_event(make_event(2'($urandom), 8'($urandom), 4'($urandom)));
      end
    end
  endtask

  // long run of line errors to drive every counter into saturation
  task automatic error_storm();
    logic [3:0] f;
    repeat (300) begin
      for (int k = 0; k < 4; k++) f[k] = ($urandom_range(0, 99) < 95);
      send_error(f);
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed checks with the standard SBUS start and end bytes
    write_reg(REG_START_VALUE, 8'h0F);
    write_reg(REG_END_VALUE, 8'h00);
    send_byte(8'h0F);                 // start value but no gap before it
    send_gap();
    send_byte(8'h0E);                 // gap seen, wrong start value
    send_gap();
    send_byte(8'h0F);                 // good start
    send_byte(8'h00);
    send_byte(8'hFF);
    send_gap();                       // gap in the middle of a frame
    send_byte(8'h5A);
    send_error(4'b1111);              // all four flags at once
    send_error(4'b1000);
    send_error(4'b0100);
    send_error(4'b0010);
    send_error(4'b0001);
    send_error(4'b0000);              // no flag: ignored
    send_event(make_event(KIND_UNUSED, 8'hFF, 4'b1111));  // unused kind: ignored
    send_gap();
    send_gap();
    send_byte(8'h0F);
    send_error(4'b1000);              // error resets a frame under way
    drain();

    // sender idles often, receiver stalls more
    write_reg(REG_START_VALUE, 8'hFF);
    write_reg(REG_END_VALUE, 8'h00);
    send_idle_pct  = 32;
    recv_stall_pct = 57;
    run_random(560);
    drain();

    // roles swapped, opposite extremes for the frame bytes
    write_reg(REG_START_VALUE, 8'h00);
    write_reg(REG_END_VALUE, 8'hFF);
    send_idle_pct  = 57;
    recv_stall_pct = 32;
    run_random(560);
    drain();

    // full rate, random frame bytes, counters driven to saturation
    write_reg(REG_START_VALUE, 8'($urandom));
    write_reg(REG_END_VALUE, 8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_storm();
    run_random(550);
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d result transactions from %0d active events.", sb.echoes, events_sent);
    $display("Frames: %0d started, %0d completed, %0d dropped; %0d error resets.",
             sb.starts_ok, sb.frames_ok, sb.frames_dropped, sb.err_resets);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: a correct run finishes in well under a tenth of this
  initial begin
    #2_000_000;
    $display("Run did not finish in time.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
